[rtl/rrsd_pkg.sv]
`default_nettype none

package rrsd_pkg;

   localparam int NUM_SERVERS_W       = 5;
   localparam int MAX_SERVERS_DEFAULT = 16;
   localparam int TIME_W              = 32;
   localparam int BUSY_W              = TIME_W + 1;
   localparam int COUNT_W             = 32;
   localparam int SERVER_W            = 4;
   localparam int QUEUE_DEPTH         = 2;

   localparam logic [NUM_SERVERS_W-1:0] NUM_SERVERS_RESET = NUM_SERVERS_W'(16);

   typedef enum logic [0:0] {
      CMD_DISPATCH = 1'b0,
      CMD_REPORT   = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      KIND_ASSIGNED = 2'd0,
      KIND_DROPPED  = 2'd1,
      KIND_REPORT   = 2'd2
   } kind_type;

   typedef struct packed {
      cmd_type             cmd;
      logic [TIME_W-1:0]   arrival_time;
      logic [TIME_W-1:0]   duration;
   } req_type;

   typedef struct packed {
      kind_type            kind;
      logic [SERVER_W-1:0] server;
      logic [COUNT_W-1:0]  served_total;
      logic                last;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SELECT,
      ST_SCAN,
      ST_EMIT
   } back_state_type;

endpackage

`default_nettype wire

[rtl/round_robin_server_dispatch_unit.sv]
// Round-robin dispatcher for a pool of up to MAX_SERVERS servers with busy timers. A
// transaction on the request queue (push/full) is either a dispatch, which goes to the first
// server whose busy-until time is at or before the arrival, searching from a rotating start
// position, or a report, which lists every server in use whose served count equals the
// highest count, in ascending order with last set on the final entry. Results come out of the
// result queue (empty/pop), oldest first. A dispatch that finds no free server yields a
// dropped result; every dispatch advances the start position. In the back end a dispatch
// first registers the free flags against the arrival, then does the rotated priority search
// and the state update; a report first finds the maximum count over the pool size in use,
// one server per cycle, then walks the servers again up to the last busiest one. Result-queue
// back-pressure can stall either. Requests and results each pass through a two-entry queue,
// so the sender and the receiver can stall independently. The user must write the pool size
// register (csr_wr_en/csr_wr_data) only while the unit is idle; the block does not enforce it;
// zero counts as one server and values above MAX_SERVERS count as MAX_SERVERS.

`default_nettype none

module round_robin_server_dispatch_unit #(
   parameter int MAX_SERVERS = rrsd_pkg::MAX_SERVERS_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // request queue
   input  wire logic                               push,
   input  wire rrsd_pkg::req_type                  req_data,
   output logic                                    full,
   // result queue
   output logic                                    empty,
   output rrsd_pkg::rsp_type                       rsp_data,
   input  wire logic                               pop,
   // pool size register
   input  wire logic                               csr_wr_en,
   input  wire logic [rrsd_pkg::NUM_SERVERS_W-1:0] csr_wr_data
);

   localparam int POOL_W = $clog2(MAX_SERVERS + 1);
   localparam int WIDE_W = (POOL_W > rrsd_pkg::NUM_SERVERS_W) ? POOL_W
                                                               : rrsd_pkg::NUM_SERVERS_W;

   logic [rrsd_pkg::NUM_SERVERS_W-1:0] num_servers_ff;
   logic [WIDE_W-1:0]                  num_wide;
   logic [POOL_W-1:0]                  pool_size;

   rrsd_pkg::req_type                  cmd_item;
   logic                               cmd_empty;
   logic                               cmd_pop;
   rrsd_pkg::rsp_type                  rsp_item;
   logic                               rsp_push;
   logic                               rsp_full;

   // Hold the pool size; take every write
   always_ff @(posedge clock) begin
      if (reset) begin
         num_servers_ff <= rrsd_pkg::NUM_SERVERS_RESET;
      end else if (csr_wr_en) begin
         num_servers_ff <= csr_wr_data;
      end
   end

   // Clamp the pool size into one server up to MAX_SERVERS
   assign num_wide = WIDE_W'(num_servers_ff);

   always_comb begin
      if (num_wide == '0) begin
         pool_size = POOL_W'(1);
      end else if (num_wide > WIDE_W'(MAX_SERVERS)) begin
         pool_size = POOL_W'(MAX_SERVERS);
      end else begin
         pool_size = POOL_W'(num_wide);
      end
   end

   // Front end: queue incoming transactions ahead of the dispatch engine
   rrsd_fifo #(
      .DEPTH     (rrsd_pkg::QUEUE_DEPTH),
      .item_type (rrsd_pkg::req_type)
   ) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (req_data),
      .full      (full),
      .pop       (cmd_pop),
      .pop_item  (cmd_item),
      .empty     (cmd_empty)
   );

   // Back end: server state, dispatch search and report walk
   rrsd_back #(
      .MAX_SERVERS (MAX_SERVERS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pool_size (pool_size),
      .cmd_item  (cmd_item),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .rsp_item  (rsp_item),
      .rsp_push  (rsp_push),
      .rsp_full  (rsp_full)
   );

   // Result queue: decouple the engine from the consumer
   rrsd_fifo #(
      .DEPTH     (rrsd_pkg::QUEUE_DEPTH),
      .item_type (rrsd_pkg::rsp_type)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_item (rsp_item),
      .full      (rsp_full),
      .pop       (pop),
      .pop_item  (rsp_data),
      .empty     (empty)
   );

endmodule

`default_nettype wire

[rtl/rrsd_fifo.sv]
`default_nettype none

module rrsd_fifo #(
   parameter int  DEPTH     = rrsd_pkg::QUEUE_DEPTH,
   parameter type item_type = logic,
   localparam int PTR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CNT_W     = $clog2(DEPTH + 1)
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire item_type push_item,
   output logic          full,
   input  wire logic     pop,
   output item_type      pop_item,
   output logic          empty
);

   item_type           slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_in;
   logic [CNT_W-1:0]   fill_ff;
   logic [CNT_W-1:0]   fill_in;
   logic               do_push;
   logic               do_pop;

   assign full     = (fill_ff == CNT_W'(DEPTH));
   assign empty    = (fill_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_item = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

[rtl/rrsd_back.sv]
`default_nettype none

module rrsd_back #(
   parameter int  MAX_SERVERS = rrsd_pkg::MAX_SERVERS_DEFAULT,
   localparam int IDX_W       = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1,
   localparam int POOL_W      = $clog2(MAX_SERVERS + 1)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [POOL_W-1:0] pool_size,
   input  wire rrsd_pkg::req_type cmd_item,
   input  wire logic              cmd_empty,
   output logic                   cmd_pop,
   output rrsd_pkg::rsp_type      rsp_item,
   output logic                   rsp_push,
   input  wire logic              rsp_full
);

   rrsd_pkg::back_state_type           state_ff;
   rrsd_pkg::back_state_type           state_in;
   rrsd_pkg::req_type                  item_ff;
   logic [MAX_SERVERS-1:0]             free_ff;
   logic [MAX_SERVERS-1:0]             free_in;
   logic [rrsd_pkg::BUSY_W-1:0]        busy_ff  [MAX_SERVERS];
   logic [rrsd_pkg::COUNT_W-1:0]       count_ff [MAX_SERVERS];
   logic [IDX_W-1:0]                   start_ff;
   logic [IDX_W-1:0]                   start_in;
   logic [IDX_W-1:0]                   walk_ff;
   logic [IDX_W-1:0]                   walk_in;
   logic [rrsd_pkg::COUNT_W-1:0]       max_ff;
   logic [IDX_W-1:0]                   lastidx_ff;

   logic [IDX_W-1:0]                   pos;
   logic [POOL_W-1:0]                  pos_inc;
   logic [MAX_SERVERS-1:0]             eligible;
   logic                               hi_hit;
   logic [IDX_W-1:0]                   hi_idx;
   logic [IDX_W-1:0]                   lo_idx;
   logic                               found;
   logic [IDX_W-1:0]                   chosen;
   logic [IDX_W-1:0]                   rd_idx;
   logic [rrsd_pkg::COUNT_W-1:0]       rd_count;
   logic [rrsd_pkg::COUNT_W-1:0]       count_inc;
   logic [rrsd_pkg::BUSY_W-1:0]        busy_new;
   logic                               scan_end;
   logic                               match;
   logic                               is_last;
   logic                               commit;

   // Free flags against the head of the command queue
   always_comb begin
      for (int i = 0; i < MAX_SERVERS; i++) begin
         free_in[i] = (busy_ff[i] <= {1'b0, cmd_item.arrival_time});
      end
   end

   // Rotated priority search, start position first
   always_comb begin
      pos     = (POOL_W'(start_ff) < pool_size) ? start_ff : '0;
      pos_inc = POOL_W'(pos) + POOL_W'(1);
      start_in = (pos_inc >= pool_size) ? '0 : IDX_W'(pos_inc);
      hi_hit  = 1'b0;
      hi_idx  = '0;
      lo_idx  = '0;
      for (int i = 0; i < MAX_SERVERS; i++) begin
         eligible[i] = free_ff[i] && (POOL_W'(i) < pool_size);
      end
      for (int i = MAX_SERVERS - 1; i >= 0; i--) begin
         if (eligible[i]) begin
            lo_idx = IDX_W'(i);
            if (IDX_W'(i) >= pos) begin
               hi_hit = 1'b1;
               hi_idx = IDX_W'(i);
            end
         end
      end
      found  = |eligible;
      chosen = hi_hit ? hi_idx : lo_idx;
   end

   assign rd_idx    = (state_ff == rrsd_pkg::ST_SELECT) ? chosen : walk_ff;
   assign rd_count  = count_ff[rd_idx];
   assign count_inc = (rd_count == '1) ? rd_count : rd_count + rrsd_pkg::COUNT_W'(1);
   assign busy_new  = {1'b0, item_ff.arrival_time} + {1'b0, item_ff.duration};
   assign scan_end  = (POOL_W'(walk_ff) == pool_size - POOL_W'(1));
   assign match     = (rd_count == max_ff);
   assign is_last   = (walk_ff == lastidx_ff);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rrsd_pkg::ST_IDLE: begin
            if (!cmd_empty) begin
               state_in = (cmd_item.cmd == rrsd_pkg::CMD_REPORT) ? rrsd_pkg::ST_SCAN
                                                                 : rrsd_pkg::ST_SELECT;
            end
         end
         rrsd_pkg::ST_SELECT: begin
            if (!rsp_full) begin
               state_in = rrsd_pkg::ST_IDLE;
            end
         end
         rrsd_pkg::ST_SCAN: begin
            if (scan_end) begin
               state_in = rrsd_pkg::ST_EMIT;
            end
         end
         rrsd_pkg::ST_EMIT: begin
            if (match && is_last && !rsp_full) begin
               state_in = rrsd_pkg::ST_IDLE;
            end
         end
         default: state_in = rrsd_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd_pop  = 1'b0;
      rsp_push = 1'b0;
      rsp_item = '0;
      commit   = 1'b0;
      walk_in  = walk_ff;
      unique case (state_ff)
         rrsd_pkg::ST_IDLE: begin
            cmd_pop = !cmd_empty;
            walk_in = '0;
         end
         rrsd_pkg::ST_SELECT: begin
            commit        = !rsp_full;
            rsp_push      = !rsp_full;
            rsp_item.last = 1'b1;
            if (found) begin
               rsp_item.kind         = rrsd_pkg::KIND_ASSIGNED;
               rsp_item.server       = rrsd_pkg::SERVER_W'(chosen);
               rsp_item.served_total = count_inc;
            end else begin
               rsp_item.kind = rrsd_pkg::KIND_DROPPED;
            end
         end
         rrsd_pkg::ST_SCAN: begin
            walk_in = scan_end ? '0 : walk_ff + IDX_W'(1);
         end
         rrsd_pkg::ST_EMIT: begin
            rsp_push              = match && !rsp_full;
            rsp_item.kind         = rrsd_pkg::KIND_REPORT;
            rsp_item.server       = rrsd_pkg::SERVER_W'(walk_ff);
            rsp_item.served_total = rd_count;
            rsp_item.last         = is_last;
            if (!match || !rsp_full) begin
               walk_in = walk_ff + IDX_W'(1);
            end
         end
         default: begin
            walk_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rrsd_pkg::ST_IDLE;
         start_ff <= '0;
         walk_ff  <= '0;
         for (int i = 0; i < MAX_SERVERS; i++) begin
            busy_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         walk_ff  <= walk_in;
         if (commit) begin
            start_ff <= start_in;
            if (found) begin
               busy_ff[chosen]  <= busy_new;
               count_ff[chosen] <= count_inc;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         item_ff    <= cmd_item;
         free_ff    <= free_in;
         max_ff     <= '0;
         lastidx_ff <= '0;
      end else if (state_ff == rrsd_pkg::ST_SCAN) begin
         if (rd_count > max_ff) begin
            max_ff     <= rd_count;
            lastidx_ff <= walk_ff;
         end else if (rd_count == max_ff) begin
            lastidx_ff <= walk_ff;
         end
      end
   end

endmodule

`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 100ps

module tb;

   localparam int POOL_MAX = rrsd_pkg::MAX_SERVERS_DEFAULT;

   // DUT connections, all inputs known from time zero
   logic                               clock       = 1'b0;
   logic                               reset       = 1'b1;
   logic                               push        = 1'b0;
   rrsd_pkg::req_type                  req_data    = '0;
   logic                               full;
   logic                               empty;
   rrsd_pkg::rsp_type                  rsp_data;
   logic                               pop         = 1'b0;
   logic                               csr_wr_en   = 1'b0;
   logic [rrsd_pkg::NUM_SERVERS_W-1:0] csr_wr_data = '0;

   // Pool model
   logic [rrsd_pkg::BUSY_W-1:0]        busy_until_model [POOL_MAX];
   logic [rrsd_pkg::COUNT_W-1:0]       served_model     [POOL_MAX];
   int                                 start_model;
   logic [rrsd_pkg::NUM_SERVERS_W-1:0] pool_reg_model;
   rrsd_pkg::rsp_type                  pending_outcomes [$];

   // Stimulus control
   logic [rrsd_pkg::TIME_W-1:0]        now_tick;
   int                                 send_gap_max    = 11;
   int                                 pop_gap_max     = 11;
   int                                 hold_off_cycles = 0;
   int                                 pop_gap;

   // Bookkeeping
   int                                 mismatch_count  = 0;
   int                                 requests_sent   = 0;
   int                                 pool_writes     = 0;
   int                                 assigned_seen   = 0;
   int                                 dropped_seen    = 0;
   int                                 report_seen     = 0;
   int                                 longest_hold    = 0;

   round_robin_server_dispatch_unit #(
      .MAX_SERVERS (POOL_MAX)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .req_data    (req_data),
      .full        (full),
      .empty       (empty),
      .rsp_data    (rsp_data),
      .pop         (pop),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Hard stop in case the DUT hangs; a correct run finishes far inside this.
   initial begin
      #40_000_000;
      $display("Mismatches found");
      $finish;
   end

   // Effective pool size: zero counts as one, anything above the maximum is clamped.
   function automatic int pool_size();
      int n;
      n = pool_reg_model;
      if (n == 0) n = 1;
      if (n > POOL_MAX) n = POOL_MAX;
      return n;
   endfunction

   // Work out the results of one accepted request and update the pool model.
   task automatic compute_outcome(input rrsd_pkg::req_type r);
      int                           n;
      int                           first;
      int                           idx;
      int                           chosen;
      int                           top_idx;
      logic [rrsd_pkg::COUNT_W-1:0] top_count;
      rrsd_pkg::rsp_type            o;
      n      = pool_size();
      chosen = -1;
      o      = '0;
      o.last = 1'b1;
      if (r.cmd == rrsd_pkg::CMD_DISPATCH) begin
         // A start position left beyond a shrunk pool restarts the search at server 0.
         first = (start_model < n) ? start_model : 0;
         for (int t = 0; t < n; t++) begin
            idx = (first + t) % n;
            if (chosen < 0 && busy_until_model[idx] <= {1'b0, r.arrival_time}) chosen = idx;
         end
         // Advance the position on every dispatch, dropped or not.
         start_model = (first + 1 >= n) ? 0 : first + 1;
         if (chosen < 0) begin
            o.kind = rrsd_pkg::KIND_DROPPED;
         end else begin
            busy_until_model[chosen] = {1'b0, r.arrival_time} + {1'b0, r.duration};
            if (served_model[chosen] != '1) served_model[chosen]++;
            o.kind         = rrsd_pkg::KIND_ASSIGNED;
            o.server       = rrsd_pkg::SERVER_W'(chosen);
            o.served_total = served_model[chosen];
         end
         pending_outcomes.insert(pending_outcomes.size(), o);
      end else begin
         top_count = '0;
         top_idx   = 0;
         for (int s = 0; s < n; s++)
            if (served_model[s] > top_count) top_count = served_model[s];
         for (int s = 0; s < n; s++)
            if (served_model[s] == top_count) top_idx = s;
         for (int s = 0; s < n; s++) begin
            if (served_model[s] == top_count) begin
               o.kind         = rrsd_pkg::KIND_REPORT;
               o.server       = rrsd_pkg::SERVER_W'(s);
               o.served_total = served_model[s];
               o.last         = (s == top_idx);
               pending_outcomes.insert(pending_outcomes.size(), o);
            end
         end
      end
   endtask

   // Offer one request after a random gap and hold it until the DUT takes it. Push is left
   // high on return so that a back-to-back transaction never lowers and raises it in one step.
   task automatic send_request(input rrsd_pkg::req_type r);
      int gap;
      gap = $urandom_range(0, send_gap_max);
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push     <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (full);
      compute_outcome(r);
      requests_sent++;
   endtask

   task automatic send_dispatch(input logic [rrsd_pkg::TIME_W-1:0] arrival,
                                input logic [rrsd_pkg::TIME_W-1:0] dur);
      rrsd_pkg::req_type r;
      r.cmd          = rrsd_pkg::CMD_DISPATCH;
      r.arrival_time = arrival;
      r.duration     = dur;
      send_request(r);
   endtask

   task automatic send_report();
      rrsd_pkg::req_type r;
      r.cmd          = rrsd_pkg::CMD_REPORT;
      r.arrival_time = $urandom;
      r.duration     = $urandom_range(1, 32'hFFFF_FFFF);
      send_request(r);
   endtask

   // Drop push and wait until every expected result has been popped.
   task automatic wait_for_results();
      push <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Only call with the DUT drained.
   task automatic write_pool_size(input logic [rrsd_pkg::NUM_SERVERS_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en      <= 1'b0;
      pool_reg_model  = value;
      pool_writes++;
   endtask

   // Mostly a rising arrival stream with durations sized so that the pool sometimes runs
   // out of free servers; some reports, and some requests arriving in the past.
   task automatic send_random_request(input bit wide_durations);
      rrsd_pkg::req_type r;
      int                n;
      int                roll;
      n    = pool_size();
      roll = $urandom_range(0, 99);
      r.cmd      = rrsd_pkg::CMD_DISPATCH;
      r.duration = $urandom_range(1, n * 8 + 8);
      if (roll < 10) begin
         send_report();
      end else begin
         if (roll < 15) begin
            r.arrival_time = $urandom_range(0, now_tick);
         end else begin
            now_tick       = now_tick + $urandom_range(0, 8);
            r.arrival_time = now_tick;
         end
         if (wide_durations && roll >= 97) r.duration = $urandom_range(1, 32'hFFFF_FFFF);
         send_request(r);
      end
   endtask

   task automatic check_result(input rrsd_pkg::rsp_type got);
      rrsd_pkg::rsp_type want;
      case (got.kind)
         rrsd_pkg::KIND_ASSIGNED: assigned_seen++;
         rrsd_pkg::KIND_DROPPED:  dropped_seen++;
         default:                 report_seen++;
      endcase
      if (pending_outcomes.size() == 0) begin
         $display("%0t: unexpected result, expected none, got kind %0d server %0d",
                  $realtime, got.kind, got.server);
         $display("%0t: unexpected result total %0d last %0b",
                  $realtime, got.served_total, got.last);
         mismatch_count++;
      end else begin
         want = pending_outcomes.pop_front();
         if (got.kind !== want.kind) begin
            $display("%0t: kind expected %0d got %0d", $realtime, want.kind, got.kind);
            mismatch_count++;
         end
         if (got.server !== want.server) begin
            $display("%0t: server expected %0d got %0d", $realtime, want.server, got.server);
            mismatch_count++;
         end
         if (got.served_total !== want.served_total) begin
            $display("%0t: served_total expected %0d got %0d",
                     $realtime, want.served_total, got.served_total);
            mismatch_count++;
         end
         if (got.last !== want.last) begin
            $display("%0t: last expected %0b got %0b", $realtime, want.last, got.last);
            mismatch_count++;
         end
      end
   endtask

   // Result side: random pop gaps, or one long hold-off when a test asks for it.
   initial begin
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_cycles > 0) begin
            pop_gap         = hold_off_cycles;
            longest_hold    = hold_off_cycles;
            hold_off_cycles = 0;
         end else begin
            pop_gap = $urandom_range(0, pop_gap_max);
         end
         if (pop_gap > 0) begin
            pop <= 1'b0;
            repeat (pop_gap) @(posedge clock);
         end
         pop <= 1'b1;
         do @(posedge clock); while (empty);
         check_result(rsp_data);
      end
   end

   // All counts are zero after reset, so every server in the pool is reported.
   task automatic test_report_after_reset();
      send_report();
   endtask

   // Round-robin order, some servers busy and a request that arrives earlier than the one before.
   task automatic test_dispatch_order();
      send_dispatch(32'd0, 32'd40);
      send_dispatch(32'd0, 32'd40);
      send_dispatch(32'd0, 32'd40);
      send_dispatch(32'd5, 32'd1);
      send_report();
      send_dispatch(32'd2, 32'd1);
   endtask

   // Shrink below the start position, zero pool size, sizes above the maximum, and servers
   // outside the pool keeping their counts while it is small.
   task automatic test_pool_limits();
      wait_for_results();
      write_pool_size(rrsd_pkg::NUM_SERVERS_W'(2));
      send_dispatch(32'd10, 32'd5);
      send_report();
      wait_for_results();
      write_pool_size(rrsd_pkg::NUM_SERVERS_W'(0));
      send_dispatch(32'd40, 32'd1);
      wait_for_results();
      write_pool_size(rrsd_pkg::NUM_SERVERS_W'(31));
      send_report();
      wait_for_results();
      write_pool_size(rrsd_pkg::NUM_SERVERS_W'(20));
      send_dispatch(32'd41, 32'd3);
      send_report();
   endtask

   // Let the result side stall for a long stretch while requests keep coming, so that both
   // queues fill and full holds the sender.
   task automatic test_backed_up_results();
      wait_for_results();
      write_pool_size(rrsd_pkg::NUM_SERVERS_W'(4));
      send_gap_max    = 0;
      hold_off_cycles = 120;
      repeat (24) send_random_request(1'b0);
      wait_for_results();
      send_gap_max = 11;
   endtask

   task automatic run_random_phase(input logic [rrsd_pkg::NUM_SERVERS_W-1:0] pool,
                                   input int items, input int gap_max,
                                   input bit wide_durations);
      wait_for_results();
      write_pool_size(pool);
      send_gap_max = gap_max;
      pop_gap_max  = gap_max;
      repeat (items) send_random_request(wide_durations);
   endtask

   // Run last: the largest times pin servers busy for good.
   task automatic test_time_limits();
      wait_for_results();
      write_pool_size(rrsd_pkg::NUM_SERVERS_W'(16));
      send_gap_max = 11;
      pop_gap_max  = 11;
      send_dispatch(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_dispatch(32'hFFFF_FFFF, 32'd1);
      send_dispatch(32'd0, 32'hFFFF_FFFF);
      send_dispatch(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_report();
   endtask

   initial begin
      for (int s = 0; s < POOL_MAX; s++) begin
         busy_until_model[s] = '0;
         served_model[s]     = '0;
      end
      start_model    = 0;
      pool_reg_model = rrsd_pkg::NUM_SERVERS_RESET;
      now_tick       = 32'h40;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_report_after_reset();
      test_dispatch_order();
      test_pool_limits();
      test_backed_up_results();
      run_random_phase(rrsd_pkg::NUM_SERVERS_W'(16), 80, 11, 1'b0);
      run_random_phase(rrsd_pkg::NUM_SERVERS_W'(1), 40, 11, 1'b0);
      run_random_phase(rrsd_pkg::NUM_SERVERS_W'(5), 60, 0, 1'b0);
      run_random_phase(rrsd_pkg::NUM_SERVERS_W'(31), 60, 11, 1'b0);
      run_random_phase(rrsd_pkg::NUM_SERVERS_W'($urandom_range(1, 16)), 50, 11, 1'b0);
      run_random_phase(rrsd_pkg::NUM_SERVERS_W'($urandom_range(1, 16)), 50, 3, 1'b0);
      run_random_phase(rrsd_pkg::NUM_SERVERS_W'($urandom_range(1, 16)), 50, 11, 1'b0);
      run_random_phase(rrsd_pkg::NUM_SERVERS_W'(8), 60, 11, 1'b1);
      test_time_limits();

      // Drain, then give any stray result time to show up.
      wait_for_results();
      repeat (50) @(posedge clock);

      $display("Run covered %0d requests over %0d pool size writes.",
               requests_sent, pool_writes);
      $display("Seen %0d assigned, %0d dropped, %0d report entries; longest hold-off %0d.",
               assigned_seen, dropped_seen, report_seen, longest_hold);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/rrsd_pkg.sv
rtl/rrsd_fifo.sv
rtl/rrsd_back.sv
rtl/round_robin_server_dispatch_unit.sv
tb/tb.sv
